### hdl/elft_pkg.sv
package elft_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned ShareW = 20;
  localparam int unsigned TotW   = 40;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgAddrW-1:0] RegThreshold = 1'b0;
  localparam logic [CfgAddrW-1:0] RegLimit     = 1'b1;
  localparam logic OpAdd  = 1'b0;
  localparam logic OpDump = 1'b1;
  localparam logic [ShareW-1:0] ShareScale = 20'd1000000;
  localparam int unsigned QuotW = 21;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StAddWr,
    StTotal,
    StPick,
    StRead,
    StDivInit,
    StDiv,
    StEmit,
    StEmpty
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic scan_clr;      // reset index for a sweep
    logic scan_step;     // advance index
    logic add_cmp;       // compare entry at index with key
    logic add_write;     // commit add result
    logic tot_acc;       // add entry count to total
    logic pick_clr;      // start a selection pass
    logic pick_cmp;      // consider entry at index for best
    logic pick_take;     // mark best as emitted, load output regs
    logic div_init;
    logic div_step;
    logic emit;
    logic emit_empty;
    logic load_in;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;      // index is at last used entry or none
    logic add_hit;       // current index matched
    logic best_found;    // a qualifying unemitted entry exists
    logic div_done;
    logic any_emitted;
    logic more_left;     // another qualifying entry remains after take
  } stat_t;

endpackage

### hdl/energy_line_frequency_table.sv
// Channel  | ports                                         | handshake
// ---------+-----------------------------------------------+-------------------------
// command  | opcode_i energy_key_i process_type_i           | start_i & !busy_o
// result   | entry_valid_o line_* table_overflow_o last_... | strobe_o, one cycle
// config   | cfg_we_i cfg_addr_i cfg_wdata_i                | cfg_we_i
//
// Add: one entry compared a cycle until a hit or the last used entry, then a
//   write state before busy drops.
// Dump: a sum sweep over used entries, then per word a selection sweep over
//   used entries, then take, divide setup, 62 divide steps, done check, emit.
// rst_ni clears the fill count, overflow flag and controller; entries are
// undefined until written. The receiver cannot stall; each word shows once.
module energy_line_frequency_table
  import elft_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                opcode_i,
  input  logic [KeyW-1:0]     energy_key_i,
  input  logic [TypeW-1:0]    process_type_i,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                strobe_o,
  output logic                entry_valid_o,
  output logic [KeyW-1:0]     line_energy_o,
  output logic [TypeW-1:0]    line_type_o,
  output logic [CntW-1:0]     line_count_o,
  output logic [ShareW-1:0]   line_share_o,
  output logic                table_overflow_o,
  output logic                last_item_o
);

  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UsedW = IdxW + 1;

  logic [KeyW-1:0] thr_q;
  logic [CntW-1:0] lim_q;
  ctrl_t ctrl;
  stat_t stat;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= KeyW'(10240);
      lim_q <= CntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegThreshold: thr_q <= cfg_wdata_i;
        RegLimit:     lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  elft_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .opcode_i,
    .stat_i(stat), .ctrl_o(ctrl), .busy_o
  );

  elft_dpath #(.Depth(TABLE_DEPTH), .IdxW(IdxW), .UsedW(UsedW)) u_dpath (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .energy_key_i, .process_type_i,
    .threshold_i(thr_q), .limit_i(lim_q),
    .strobe_o, .entry_valid_o, .line_energy_o, .line_type_o,
    .line_count_o, .line_share_o, .table_overflow_o, .last_item_o
  );

`ifndef NO_ASSERTIONS
  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> line_share_o <= ShareScale) else $error("share out of range");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !entry_valid_o) |-> last_item_o) else $error("empty not last");
  a_busy_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_item_o) |-> busy_o) else $error("idle mid dump");
`endif

endmodule

### hdl/elft_ctrl.sv
module elft_ctrl
  import elft_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  opcode_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (start_i) begin
          ctrl_o.load_in  = 1'b1;
          ctrl_o.scan_clr = 1'b1;
          state_d = (opcode_i == OpDump) ? StTotal : StScan;
        end
      end
      StScan: begin
        ctrl_o.add_cmp = 1'b1;
        if (stat_i.add_hit || stat_i.scan_end) state_d = StAddWr;
        else ctrl_o.scan_step = 1'b1;
      end
      StAddWr: begin
        ctrl_o.add_write = 1'b1;
        state_d = StIdle;
      end
      StTotal: begin
        ctrl_o.tot_acc = 1'b1;
        if (stat_i.scan_end) begin
          ctrl_o.scan_clr = 1'b1;
          ctrl_o.pick_clr = 1'b1;
          state_d = StPick;
        end else ctrl_o.scan_step = 1'b1;
      end
      StPick: begin
        ctrl_o.pick_cmp = 1'b1;
        if (stat_i.scan_end) state_d = StRead;
        else ctrl_o.scan_step = 1'b1;
      end
      StRead: begin
        if (stat_i.best_found) begin
          ctrl_o.pick_take = 1'b1;
          state_d = StDivInit;
        end else if (stat_i.any_emitted) begin
          state_d = StIdle;
        end else state_d = StEmpty;
      end
      StDivInit: begin
        ctrl_o.div_init = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = StEmit;
      end
      StEmit: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.scan_clr = 1'b1;
        ctrl_o.pick_clr = 1'b1;
        state_d = stat_i.more_left ? StPick : StIdle;
      end
      StEmpty: begin
        ctrl_o.emit_empty = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

### hdl/elft_dpath.sv
module elft_dpath
  import elft_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6,
  parameter int unsigned UsedW = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  output stat_t             stat_o,
  input  logic [KeyW-1:0]   energy_key_i,
  input  logic [TypeW-1:0]  process_type_i,
  input  logic [KeyW-1:0]   threshold_i,
  input  logic [CntW-1:0]   limit_i,
  output logic              strobe_o,
  output logic              entry_valid_o,
  output logic [KeyW-1:0]   line_energy_o,
  output logic [TypeW-1:0]  line_type_o,
  output logic [CntW-1:0]   line_count_o,
  output logic [ShareW-1:0] line_share_o,
  output logic              table_overflow_o,
  output logic              last_item_o
);

  // entry store: one write port, one registered read port addressed by the
  // next scan index, so the read data always belongs to idx_q
  logic [KeyW-1:0]  energy_q [Depth];
  logic [CntW-1:0]  count_q  [Depth];
  logic [TypeW-1:0] type_q   [Depth];
  logic [Depth-1:0] done_q;

  logic [UsedW-1:0] used_q;
  logic             ovf_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [KeyW-1:0]  rd_energy_q;
  logic [CntW-1:0]  rd_count_q;
  logic [TypeW-1:0] rd_type_q;
  logic [KeyW-1:0]  key_q;
  logic [TypeW-1:0] ptype_q;
  logic             hit_q;
  logic [IdxW-1:0]  hit_idx_q;
  logic [CntW-1:0]  hit_cnt_q;
  logic [TotW-1:0]  total_q;
  logic             best_ok_q;
  logic [IdxW-1:0]  best_q;
  logic [CntW-1:0]  best_cnt_q;
  logic [KeyW-1:0]  best_energy_q;
  logic [TypeW-1:0] best_type_q;
  logic             seen_q;
  logic             more_q;
  logic             any_q;
  logic [5:0]       div_cnt_q;
  logic [TotW:0]    rem_q;
  logic [QuotW-1:0] quo_q;
  logic [TotW+QuotW:0] num_q;

  logic scan_end, cur_hit, qual, cand;
  logic [UsedW-1:0] idx_ext;
  logic [TotW:0] rem_sh, div2;
  logic [CntW-1:0] cur_cnt;

  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.scan_clr) idx_d = '0;
    else if (ctrl_i.scan_step) idx_d = idx_q + 1'b1;
  end

  assign idx_ext  = {1'b0, idx_q};
  assign scan_end = (used_q == '0) || (idx_ext + 1'b1 >= used_q);
  assign cur_cnt  = rd_count_q;
  assign cur_hit  = (used_q != '0) && (rd_energy_q == key_q);
  assign qual     = (used_q != '0) && !done_q[idx_q] && (cur_cnt > limit_i);
  assign cand     = qual && (!best_ok_q || cur_cnt > best_cnt_q);
  assign div2     = {total_q, 1'b0};
  assign rem_sh   = {rem_q[TotW-1:0], num_q[TotW+QuotW]};

  always_comb begin
    stat_o = '0;
    stat_o.scan_end    = scan_end;
    stat_o.add_hit     = cur_hit;
    stat_o.best_found  = best_ok_q;
    stat_o.div_done    = (div_cnt_q == 6'd0);
    stat_o.any_emitted = any_q;
    stat_o.more_left   = more_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      ovf_q    <= 1'b0;
      strobe_o <= 1'b0;
      idx_q    <= '0;
      done_q   <= '0;
      any_q    <= 1'b0;
    end else begin
      strobe_o <= ctrl_i.emit || ctrl_i.emit_empty;
      idx_q    <= idx_d;
      if (ctrl_i.load_in) begin
        done_q <= '0;
        any_q  <= 1'b0;
      end
      if (ctrl_i.add_write && key_q >= threshold_i) begin
        if (hit_q) begin
          // counted in the store block
        end else if (used_q >= UsedW'(Depth)) ovf_q <= 1'b1;
        else used_q <= used_q + 1'b1;
      end
      if (ctrl_i.pick_take) begin
        done_q[best_q] <= 1'b1;
        any_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_energy_q <= energy_q[idx_d];
    rd_count_q  <= count_q[idx_d];
    rd_type_q   <= type_q[idx_d];
    if (ctrl_i.load_in) begin
      key_q   <= energy_key_i;
      ptype_q <= process_type_i;
      total_q <= '0;
    end
    if (ctrl_i.add_cmp) begin
      hit_q     <= cur_hit;
      hit_idx_q <= idx_q;
      hit_cnt_q <= cur_cnt;
    end
    if (ctrl_i.add_write && key_q >= threshold_i) begin
      if (hit_q) begin
        if (hit_cnt_q != '1) count_q[hit_idx_q] <= hit_cnt_q + 1'b1;
      end else if (used_q < UsedW'(Depth)) begin
        energy_q[used_q[IdxW-1:0]] <= key_q;
        count_q[used_q[IdxW-1:0]]  <= CntW'(1);
        type_q[used_q[IdxW-1:0]]   <= ptype_q;
      end
    end
    if (ctrl_i.tot_acc && used_q != '0) total_q <= total_q + TotW'(cur_cnt);
    // a second qualifying entry in one pass means one remains after the take
    if (ctrl_i.pick_clr) begin
      best_ok_q <= 1'b0;
      seen_q    <= 1'b0;
      more_q    <= 1'b0;
    end else if (ctrl_i.pick_cmp && qual) begin
      seen_q <= 1'b1;
      if (seen_q) more_q <= 1'b1;
    end
    if (ctrl_i.pick_cmp && cand) begin
      best_ok_q     <= 1'b1;
      best_q        <= idx_q;
      best_cnt_q    <= cur_cnt;
      best_energy_q <= rd_energy_q;
      best_type_q   <= rd_type_q;
    end
    if (ctrl_i.pick_take) begin
      line_energy_o <= best_energy_q;
      line_type_o   <= best_type_q;
      line_count_o  <= best_cnt_q;
    end
    // share = (2*cnt*1e6 + total) / (2*total), restoring division
    if (ctrl_i.div_init) begin
      num_q     <= (TotW+QuotW+1)'(line_count_o) * (TotW+QuotW+1)'(2*1000000)
                   + (TotW+QuotW+1)'(total_q);
      rem_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= 6'(TotW + QuotW + 1);
    end else if (ctrl_i.div_step && div_cnt_q != 6'd0) begin
      num_q <= {num_q[TotW+QuotW-1:0], 1'b0};
      if (rem_sh >= div2) begin
        rem_q <= rem_sh - div2;
        quo_q <= {quo_q[QuotW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QuotW-2:0], 1'b0};
      end
      div_cnt_q <= div_cnt_q - 1'b1;
    end
    if (ctrl_i.emit) begin
      entry_valid_o    <= 1'b1;
      line_share_o     <= (quo_q > QuotW'(ShareScale)) ? ShareScale : quo_q[ShareW-1:0];
      table_overflow_o <= ovf_q;
      last_item_o      <= !more_q;
    end
    if (ctrl_i.emit_empty) begin
      entry_valid_o    <= 1'b0;
      line_energy_o    <= '0;
      line_type_o      <= '0;
      line_count_o     <= '0;
      line_share_o     <= '0;
      table_overflow_o <= ovf_q;
      last_item_o      <= 1'b1;
    end
  end

endmodule
